>>> rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Item codes, result status codes, memory command and fixed limits.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // Largest chunk a write item may carry, and most bytes one read returns
  localparam int unsigned CHUNK_BYTES = 8;
  localparam int unsigned MAX_READ    = 64;

  // Width used for all fill / count comparisons (widest count field)
  localparam int unsigned CMP_W = 16;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_EMPTY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_LEN  = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/brb_ifs.sv
// ----------------------------------------------------------------------------
// brb_ifs: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface brb_in_if;
  logic            valid;
  logic            ready;
  brb_pkg::mode_t  mode;
  logic [63:0]     chunk_bytes;
  logic [3:0]      chunk_count;
  logic [6:0]      read_request;
  logic [15:0]     discard_count;

  modport source (output valid, mode, chunk_bytes, chunk_count, read_request,
                  discard_count, input ready);
  modport sink   (input valid, mode, chunk_bytes, chunk_count, read_request,
                  discard_count, output ready);
endinterface

interface brb_out_if;
  logic              valid;
  logic              ready;
  brb_pkg::status_t  status;
  logic [7:0]        read_byte;
  logic [6:0]        granted_count;
  logic [7:0]        fill_level;
  logic              last;

  modport source (output valid, status, read_byte, granted_count, fill_level,
                  last, input ready);
  modport sink   (input valid, status, read_byte, granted_count, fill_level,
                  last, output ready);
endinterface

interface brb_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem: single-port byte store
// One write or one read per cycle; read data registered and held.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mem #(
  parameter int unsigned DEPTH = 255,
  parameter int unsigned AW    = 8
) (
  input  wire                    clk,
  input  brb_pkg::mem_cmd_t      cmd,
  input  wire [AW-1:0]           addr,
  input  wire [7:0]              wdata,
  output logic [7:0]             rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/brb_wrap_add.sv
// ----------------------------------------------------------------------------
// brb_wrap_add: shared ring index adder
// (a + b) mod CAPACITY for a + b below twice CAPACITY: add, compare, subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_wrap_add #(
  parameter int unsigned CAPACITY = 255,
  parameter int unsigned AW       = 8,
  parameter int unsigned FW       = 8
) (
  input  wire [AW-1:0]  a,
  input  wire [FW-1:0]  b,
  output logic [AW-1:0] sum
);

  localparam logic [FW:0] CAP_W = (FW+1)'(CAPACITY);

  logic [FW:0] raw;

  always_comb begin
    raw = (FW+1)'(a) + (FW+1)'(b);
    if (raw >= CAP_W) begin
      sum = AW'(raw - CAP_W);
    end else begin
      sum = AW'(raw);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer: circular byte FIFO with peek, consume and discard
// Sequence: a write finds the tail position, writes its n bytes, then results;
//   a read does a memory read, then a result, per returned byte; discard,
//   empty, refused, zero-length or empty-store items give one result; output stalls hold results.
// Throughput: one item at a time; the single-port byte memory and the
//   shared index adder are walked one byte per step.
// Reset: head, fill and consume_on_read clear; store contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer #(
  parameter int unsigned CAPACITY = 255
) (
  input  wire          clk,
  input  wire          rst_n,
  brb_in_if.sink       in_if,
  brb_out_if.source    out_if,
  brb_cfg_if.sink      cfg_if
);

  localparam int unsigned AW = $clog2(CAPACITY);      // ring index
  localparam int unsigned FW = $clog2(CAPACITY + 1);  // fill count
  localparam int unsigned CW = brb_pkg::CMP_W;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_WR_POS  = 7'b0000010,  // compute tail position
    ST_WR_BYTE = 7'b0000100,  // write one chunk byte per cycle
    ST_RD_ADDR = 7'b0001000,  // issue memory read
    ST_RD_OUT  = 7'b0010000,  // present read byte
    ST_DISC    = 7'b0100000,  // advance head past dropped bytes
    ST_RESP    = 7'b1000000   // single result of an item that returns no bytes
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [6:0]        idx_r, idx_nxt;        // bytes done in this item
  logic [6:0]        granted_r, granted_nxt;
  logic [3:0]        cnt_r, cnt_nxt;        // chunk length
  logic [63:0]       chunk_r, chunk_nxt;    // shifts right a byte per write
  logic [15:0]       disc_r, disc_nxt;
  logic              drop_all_r, drop_all_nxt;
  brb_pkg::status_t  status_r, status_nxt;
  logic              consume_r;

  // result register
  logic              out_valid_r;
  brb_pkg::status_t  out_status_r, out_status_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [6:0]        out_granted_r, out_granted_nxt;
  logic [7:0]        out_fill_r, out_fill_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;
  logic              out_free;

  // shared adder and memory
  logic [AW-1:0]     wa;
  logic [FW-1:0]     wb;
  logic [AW-1:0]     wsum;
  brb_pkg::mem_cmd_t mem_cmd;
  logic [7:0]        mem_rdata;

  // item decode helpers
  logic              in_fire;
  logic [CW-1:0]     fill_w;
  logic [CW-1:0]     space_w;
  logic [6:0]        req_sat;
  logic [6:0]        grant;

  brb_wrap_add #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .FW       (FW)
  ) u_wrap (
    .a   (wa),
    .b   (wb),
    .sum (wsum)
  );

  brb_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (pos_r),
    .wdata (chunk_r[7:0]),
    .rdata (mem_rdata)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_if.valid && (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  // Fill and free space at comparison width; the grant of a read is compared at it
  assign fill_w  = CW'(fill_r);
  assign space_w = CW'(CAPACITY) - fill_w;
  assign req_sat = (in_if.read_request > 7'(brb_pkg::MAX_READ)) ?
                   7'(brb_pkg::MAX_READ) : in_if.read_request;
  assign grant   = (CW'(req_sat) < fill_w) ? req_sat : 7'(fill_r);

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    pos_nxt         = pos_r;
    idx_nxt         = idx_r;
    granted_nxt     = granted_r;
    cnt_nxt         = cnt_r;
    chunk_nxt       = chunk_r;
    disc_nxt        = disc_r;
    drop_all_nxt    = drop_all_r;
    status_nxt      = status_r;
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_granted_nxt = out_granted_r;
    out_fill_nxt    = out_fill_r;
    out_last_nxt    = out_last_r;
    mem_cmd         = '0;
    wa              = pos_r;
    wb              = FW'(1);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_if.mode)
            brb_pkg::MODE_WRITE: begin
              chunk_nxt = in_if.chunk_bytes;
              cnt_nxt   = in_if.chunk_count;
              idx_nxt   = '0;
              // refusal checks in priority order
              if (fill_w == CW'(CAPACITY)) begin
                status_nxt = brb_pkg::STAT_FULL;
                state_nxt  = ST_RESP;
              end else if (in_if.chunk_count == 4'd0) begin
                status_nxt = brb_pkg::STAT_BAD_LEN;
                state_nxt  = ST_RESP;
              end else if ((in_if.chunk_count > 4'(brb_pkg::CHUNK_BYTES)) ||
                           (CW'(in_if.chunk_count) > space_w)) begin
                status_nxt = brb_pkg::STAT_TOO_LONG;
                state_nxt  = ST_RESP;
              end else begin
                status_nxt = brb_pkg::STAT_OK;
                state_nxt  = ST_WR_POS;
              end
            end
            brb_pkg::MODE_READ: begin
              status_nxt = brb_pkg::STAT_OK;
              if (in_if.read_request == 7'd0) begin
                status_nxt = brb_pkg::STAT_BAD_LEN;
                state_nxt  = ST_RESP;
              end else if (grant == 7'd0) begin
                state_nxt = ST_RESP;   // empty store: one bare result
              end else begin
                pos_nxt     = head_r;
                idx_nxt     = '0;
                granted_nxt = grant;
                // fill after consume is reported on every byte of the read
                drop_all_nxt = consume_r && (fill_w == CW'(grant));
                if (consume_r) begin
                  fill_nxt = fill_r - FW'(grant);
                end
                state_nxt = ST_RD_ADDR;
              end
            end
            brb_pkg::MODE_DISCARD: begin
              disc_nxt   = in_if.discard_count;
              status_nxt = brb_pkg::STAT_OK;
              state_nxt  = ST_DISC;
            end
            brb_pkg::MODE_EMPTY: begin
              head_nxt   = '0;
              fill_nxt   = '0;
              status_nxt = brb_pkg::STAT_OK;
              state_nxt  = ST_RESP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_WR_POS: begin
        wa        = head_r;
        wb        = fill_r;
        pos_nxt   = wsum;
        state_nxt = ST_WR_BYTE;
      end

      ST_WR_BYTE: begin
        mem_cmd.wr_en = 1'b1;
        pos_nxt       = wsum;
        chunk_nxt     = {8'd0, chunk_r[63:8]};
        idx_nxt       = idx_r + 7'd1;
        if (idx_r + 7'd1 == 7'(cnt_r)) begin
          fill_nxt  = fill_r + FW'(cnt_r);
          state_nxt = ST_RESP;
        end
      end

      ST_RD_ADDR: begin
        mem_cmd.rd_en = 1'b1;
        pos_nxt       = wsum;
        idx_nxt       = idx_r + 7'd1;
        state_nxt     = ST_RD_OUT;
      end

      ST_RD_OUT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_nxt  = brb_pkg::STAT_OK;
          out_byte_nxt    = mem_rdata;
          out_granted_nxt = granted_r;
          out_fill_nxt    = 8'(fill_r);
          out_last_nxt    = (idx_r == granted_r);
          if (idx_r == granted_r) begin
            // pos has walked to head + granted, the new head on consume
            if (consume_r) begin
              head_nxt = drop_all_r ? '0 : pos_r;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD_ADDR;
          end
        end
      end

      ST_DISC: begin
        wa = head_r;
        wb = FW'(disc_r);
        if (disc_r == 16'd0) begin
          head_nxt = head_r;
        end else if (CW'(disc_r) < fill_w) begin
          head_nxt = wsum;
          fill_nxt = fill_r - FW'(disc_r);
        end else begin
          head_nxt = '0;
          fill_nxt = '0;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_nxt  = status_r;
          out_byte_nxt    = 8'd0;
          out_granted_nxt = 7'd0;
          out_fill_nxt    = 8'(fill_r);
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      consume_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      if (cfg_if.valid) begin
        consume_r <= cfg_if.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and sequencing registers, no reset needed
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    idx_r         <= idx_nxt;
    granted_r     <= granted_nxt;
    cnt_r         <= cnt_nxt;
    chunk_r       <= chunk_nxt;
    disc_r        <= disc_nxt;
    drop_all_r    <= drop_all_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_byte_r    <= out_byte_nxt;
    out_granted_r <= out_granted_nxt;
    out_fill_r    <= out_fill_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.read_byte     = out_byte_r;
  assign out_if.granted_count = out_granted_r;
  assign out_if.fill_level    = out_fill_r;
  assign out_if.last          = out_last_r;

endmodule

`default_nettype wire
